>>> rtl/assert_macros.svh
// Assertion macros used by the port-level checker of the glyph text renderer.
// Needs nothing else; each file that asserts includes it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under a disable condition.
`define ASSERT_SAME(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under a disable condition.
`define ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/gtpr_pkg.sv
// Shared constants, opcodes and the command format of the glyph text renderer.
// Used by the front, queue, back and top-level files; depends on nothing.
`timescale 1ns / 1ps

package gtpr_pkg;

  localparam int NUM_GLYPHS_DEF       = 256;
  localparam int MAX_GLYPH_WIDTH_DEF  = 8;
  localparam int MAX_GLYPH_HEIGHT_DEF = 8;
  localparam int QUEUE_DEPTH_DEF      = 2;

  localparam int OPCODE_W    = 2;
  localparam int CODE_W      = 21;
  localparam int ROW_IDX_W   = 3;
  localparam int ROW_BITS_W  = 8;
  localparam int COORD_W     = 12;
  localparam int GEOM_W      = 4;
  localparam int GLYPH_IDX_W = 16;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 24;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic [COORD_W-1:0] MARGIN       = 12'd10;
  localparam logic [COORD_W-1:0] COORD_MAX    = 12'd4095;
  localparam logic [CODE_W-1:0]  NEWLINE_CODE = 21'd10;
  localparam logic [GEOM_W-1:0]  GEOM_RESET   = 4'd8;

  localparam logic REG_GLYPH_WIDTH  = 1'b0;
  localparam logic REG_GLYPH_HEIGHT = 1'b1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE_ROW  = 2'd0,
    OP_START_PAGE = 2'd1,
    OP_DRAW       = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    CMD_WRITE   = 3'd0,
    CMD_PAGE    = 3'd1,
    CMD_NEWLINE = 3'd2,
    CMD_SKIP    = 3'd3,
    CMD_DRAW    = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                kind;
    logic [GLYPH_IDX_W-1:0]   glyph;
    logic [ROW_IDX_W-1:0]     row;
    logic [ROW_BITS_W-1:0]    bits;
  } cmd_t;

endpackage

>>> rtl/glyph_text_pixel_renderer.sv
// Draw command: dispatched from the idle state, then the glyph rows are fetched, then the eff_w * eff_h
// positions are scanned (one pixel position per cycle while the output is not stalled), and the
// flush state flags the last point.
// Row writes, page starts, newlines and skipped code points are each handled in the idle state of the back end.
// A two-entry command queue lets input transactions continue while the back end draws.
// After reset the glyph store is cleared, one row per cycle for all NUM_GLYPHS * MAX_GLYPH_HEIGHT
// rows (2048 by default), with s_tready low; the cursor returns to (10,10).
`timescale 1ns / 1ps

module glyph_text_pixel_renderer #(
  parameter int NUM_GLYPHS       = gtpr_pkg::NUM_GLYPHS_DEF,
  parameter int MAX_GLYPH_WIDTH  = gtpr_pkg::MAX_GLYPH_WIDTH_DEF,
  parameter int MAX_GLYPH_HEIGHT = gtpr_pkg::MAX_GLYPH_HEIGHT_DEF,
  parameter int QUEUE_DEPTH      = gtpr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // code_point[20:0], row_index[23:21], row_bits[31:24]
  input  logic [gtpr_pkg::IN_DATA_W-1:0]  s_tdata,
  // opcode[1:0]
  input  logic [gtpr_pkg::OPCODE_W-1:0]   s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // pixel_x[11:0], pixel_y[23:12]
  output logic [gtpr_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tlast,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gtpr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [gtpr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [gtpr_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  logic [gtpr_pkg::GEOM_W-1:0] glyph_width;
  logic [gtpr_pkg::GEOM_W-1:0] glyph_height;
  logic                        cfg_write;
  logic                        clearing;
  logic                        q_full;
  logic                        q_push;
  logic                        q_pop;
  logic                        q_empty;
  gtpr_pkg::cmd_t              q_in;
  gtpr_pkg::cmd_t              q_out;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_width  <= gtpr_pkg::GEOM_RESET;
      glyph_height <= gtpr_pkg::GEOM_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == gtpr_pkg::REG_GLYPH_WIDTH) begin
        glyph_width <= pwdata[gtpr_pkg::GEOM_W-1:0];
      end else begin
        glyph_height <= pwdata[gtpr_pkg::GEOM_W-1:0];
      end
    end
  end

  always_comb begin
    case (paddr[2])
      gtpr_pkg::REG_GLYPH_WIDTH: begin
        prdata = {{(gtpr_pkg::APB_DATA_W - gtpr_pkg::GEOM_W){1'b0}}, glyph_width};
      end
      default: begin
        prdata = {{(gtpr_pkg::APB_DATA_W - gtpr_pkg::GEOM_W){1'b0}}, glyph_height};
      end
    endcase
  end

  gtpr_front #(
    .NUM_GLYPHS       (NUM_GLYPHS),
    .MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT)
  ) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .clearing (clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  gtpr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  gtpr_back #(
    .NUM_GLYPHS       (NUM_GLYPHS),
    .MAX_GLYPH_WIDTH  (MAX_GLYPH_WIDTH),
    .MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .glyph_width  (glyph_width),
    .glyph_height (glyph_height),
    .q_empty      (q_empty),
    .q_data       (q_out),
    .q_pop        (q_pop),
    .clearing     (clearing),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast)
  );

endmodule

>>> rtl/gtpr_front.sv
// Input side of the glyph text renderer: accepts transactions and turns them into commands.
// Depends on gtpr_pkg; feeds gtpr_fifo.
`timescale 1ns / 1ps

module gtpr_front #(
  parameter int NUM_GLYPHS       = gtpr_pkg::NUM_GLYPHS_DEF,
  parameter int MAX_GLYPH_HEIGHT = gtpr_pkg::MAX_GLYPH_HEIGHT_DEF
) (
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [gtpr_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic [gtpr_pkg::OPCODE_W-1:0]  s_tuser,
  input  logic                           clearing,
  input  logic                           q_full,
  output logic                           q_push,
  output gtpr_pkg::cmd_t                 q_data
);

  logic [gtpr_pkg::CODE_W-1:0]     code_point;
  logic [gtpr_pkg::ROW_IDX_W-1:0]  row_index;
  logic [gtpr_pkg::ROW_BITS_W-1:0] row_bits;
  logic                            glyph_ok;
  logic                            row_ok;
  logic                            keep;

  assign code_point = s_tdata[20:0];
  assign row_index  = s_tdata[23:21];
  assign row_bits   = s_tdata[31:24];

  assign glyph_ok = (32'(code_point) < NUM_GLYPHS);
  assign row_ok   = (32'(row_index) < MAX_GLYPH_HEIGHT);
  assign s_tready = !clearing && !q_full;

  always_comb begin
    q_data.glyph = code_point[gtpr_pkg::GLYPH_IDX_W-1:0];
    q_data.row   = row_index;
    q_data.bits  = row_bits;
    q_data.kind  = gtpr_pkg::CMD_SKIP;
    keep         = 1'b0;
    case (gtpr_pkg::opcode_t'(s_tuser))
      gtpr_pkg::OP_WRITE_ROW: begin
        q_data.kind = gtpr_pkg::CMD_WRITE;
        keep        = glyph_ok && row_ok;
      end
      gtpr_pkg::OP_START_PAGE: begin
        q_data.kind = gtpr_pkg::CMD_PAGE;
        keep        = 1'b1;
      end
      gtpr_pkg::OP_DRAW: begin
        keep = 1'b1;
        if (code_point == gtpr_pkg::NEWLINE_CODE) begin
          q_data.kind = gtpr_pkg::CMD_NEWLINE;
        end else if (glyph_ok) begin
          q_data.kind = gtpr_pkg::CMD_DRAW;
        end else begin
          q_data.kind = gtpr_pkg::CMD_SKIP;
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push = s_tvalid && s_tready && keep;

endmodule

>>> rtl/gtpr_fifo.sv
// Short command queue between the front and back of the glyph text renderer.
// Depends on gtpr_pkg for the command format.
`timescale 1ns / 1ps

module gtpr_fifo #(
  parameter int DEPTH = gtpr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  gtpr_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output gtpr_pkg::cmd_t dout,
  output logic           empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  gtpr_pkg::cmd_t  entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

endmodule

>>> rtl/gtpr_back.sv
// Execution side of the glyph text renderer: glyph store, cursor, pixel scan and output register.
// Depends on gtpr_pkg; takes commands from gtpr_fifo.
`timescale 1ns / 1ps

module gtpr_back #(
  parameter int NUM_GLYPHS       = gtpr_pkg::NUM_GLYPHS_DEF,
  parameter int MAX_GLYPH_WIDTH  = gtpr_pkg::MAX_GLYPH_WIDTH_DEF,
  parameter int MAX_GLYPH_HEIGHT = gtpr_pkg::MAX_GLYPH_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [gtpr_pkg::GEOM_W-1:0]     glyph_width,
  input  logic [gtpr_pkg::GEOM_W-1:0]     glyph_height,
  input  logic                            q_empty,
  input  gtpr_pkg::cmd_t                  q_data,
  output logic                            q_pop,
  output logic                            clearing,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [gtpr_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tlast
);

  localparam int GW         = gtpr_pkg::GEOM_W;
  localparam int XYW        = gtpr_pkg::COORD_W;
  localparam int DEPTH_ROWS = NUM_GLYPHS * MAX_GLYPH_HEIGHT;
  localparam int AW         = (DEPTH_ROWS > 1) ? $clog2(DEPTH_ROWS) : 1;
  localparam int XIW        = (MAX_GLYPH_WIDTH > 1) ? $clog2(MAX_GLYPH_WIDTH) : 1;
  localparam int YIW        = (MAX_GLYPH_HEIGHT > 1) ? $clog2(MAX_GLYPH_HEIGHT) : 1;
  localparam int BW         = gtpr_pkg::ROW_BITS_W;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_FLUSH = 5'b10000
  } back_state_t;

  function automatic logic [XYW-1:0] sat_add(input logic [XYW-1:0] a, input logic [GW-1:0] b);
    logic [XYW:0] s;
    s = {1'b0, a} + {{(XYW + 1 - GW){1'b0}}, b};
    return s[XYW] ? gtpr_pkg::COORD_MAX : s[XYW-1:0];
  endfunction

  back_state_t                state;
  logic [AW-1:0]              clr_addr;
  logic [AW-1:0]              base;
  logic [GW-1:0]              rcnt;
  logic                       rd_valid;
  logic [YIW-1:0]             rd_row;
  logic [MAX_GLYPH_WIDTH-1:0] rd_q;
  logic [MAX_GLYPH_WIDTH-1:0] rows [MAX_GLYPH_HEIGHT];
  logic [MAX_GLYPH_WIDTH-1:0] mem  [DEPTH_ROWS];
  logic [GW-1:0]              xcnt;
  logic [GW-1:0]              ycnt;
  logic                       pend_valid;
  logic [XYW-1:0]             pend_x;
  logic [XYW-1:0]             pend_y;
  logic                       out_valid;
  logic [XYW-1:0]             out_x;
  logic [XYW-1:0]             out_y;
  logic                       out_last;
  logic [XYW-1:0]             cursor_col;
  logic [XYW-1:0]             cursor_row;

  logic [GW-1:0]              eff_w;
  logic [GW-1:0]              eff_h;
  logic                       out_free;
  logic                       cur_bit;
  logic [XYW-1:0]             cur_x;
  logic [XYW-1:0]             cur_y;
  logic                       scan_step;
  logic                       issue;
  logic [AW-1:0]              cmd_addr;
  logic [AW-1:0]              draw_base;
  logic [AW-1:0]              rd_addr;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [MAX_GLYPH_WIDTH-1:0] mem_wdata;
  logic [MAX_GLYPH_WIDTH+BW-1:0] bits_ext;

  assign eff_w = (32'(glyph_width) > MAX_GLYPH_WIDTH) ? GW'(MAX_GLYPH_WIDTH) : glyph_width;
  assign eff_h = (32'(glyph_height) > MAX_GLYPH_HEIGHT) ? GW'(MAX_GLYPH_HEIGHT) : glyph_height;

  assign clearing  = (state == ST_CLEAR);
  assign q_pop     = (state == ST_IDLE) && !q_empty;
  assign out_free  = !out_valid || m_tready;
  assign cur_bit   = rows[ycnt[YIW-1:0]][xcnt[XIW-1:0]];
  assign cur_x     = sat_add(cursor_col, xcnt);
  assign cur_y     = sat_add(cursor_row, ycnt);
  assign scan_step = !cur_bit || !pend_valid || out_free;
  assign issue     = (state == ST_READ) && (rcnt < eff_h);

  assign cmd_addr  = AW'(32'(q_data.glyph) * MAX_GLYPH_HEIGHT + 32'(q_data.row));
  assign draw_base = AW'(32'(q_data.glyph) * MAX_GLYPH_HEIGHT);
  assign rd_addr   = base + AW'(rcnt);
  assign bits_ext  = {{MAX_GLYPH_WIDTH{1'b0}}, q_data.bits};

  assign mem_we    = clearing || (q_pop && (q_data.kind == gtpr_pkg::CMD_WRITE));
  assign mem_waddr = clearing ? clr_addr : cmd_addr;
  assign mem_wdata = clearing ? '0 : bits_ext[MAX_GLYPH_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      rcnt       <= '0;
      xcnt       <= '0;
      ycnt       <= '0;
      rd_valid   <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      cursor_col <= gtpr_pkg::MARGIN;
      cursor_row <= gtpr_pkg::MARGIN;
    end else begin
      rd_valid <= issue;
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH_ROWS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_pop) begin
            case (q_data.kind)
              gtpr_pkg::CMD_PAGE: begin
                cursor_col <= gtpr_pkg::MARGIN;
                cursor_row <= gtpr_pkg::MARGIN;
              end
              gtpr_pkg::CMD_NEWLINE: begin
                cursor_col <= gtpr_pkg::MARGIN;
                cursor_row <= sat_add(cursor_row, eff_h);
              end
              gtpr_pkg::CMD_SKIP: begin
                cursor_col <= sat_add(cursor_col, eff_w);
              end
              gtpr_pkg::CMD_DRAW: begin
                if (eff_w == '0 || eff_h == '0) begin
                  cursor_col <= sat_add(cursor_col, eff_w);
                end else begin
                  base  <= draw_base;
                  rcnt  <= '0;
                  state <= ST_READ;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_READ: begin
          if (issue) begin
            rcnt <= rcnt + 1'b1;
          end else if (!rd_valid) begin
            xcnt  <= '0;
            ycnt  <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_step) begin
            if (cur_bit) begin
              pend_valid <= 1'b1;
              if (pend_valid) begin
                out_valid <= 1'b1;
              end
            end
            if (ycnt == eff_h - 1'b1) begin
              ycnt <= '0;
              if (xcnt == eff_w - 1'b1) begin
                state <= ST_FLUSH;
              end else begin
                xcnt <= xcnt + 1'b1;
              end
            end else begin
              ycnt <= ycnt + 1'b1;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_valid) begin
            cursor_col <= sat_add(cursor_col, eff_w);
            state      <= ST_IDLE;
          end else if (out_free) begin
            out_valid  <= 1'b1;
            pend_valid <= 1'b0;
            cursor_col <= sat_add(cursor_col, eff_w);
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_row <= rcnt[YIW-1:0];
    end
    if (rd_valid) begin
      rows[rd_row] <= rd_q;
    end
    if (state == ST_SCAN && scan_step && cur_bit) begin
      pend_x <= cur_x;
      pend_y <= cur_y;
      if (pend_valid) begin
        out_x    <= pend_x;
        out_y    <= pend_y;
        out_last <= 1'b0;
      end
    end
    if (state == ST_FLUSH && pend_valid && out_free) begin
      out_x    <= pend_x;
      out_y    <= pend_y;
      out_last <= 1'b1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_y, out_x};
  assign m_tlast  = out_last;

endmodule

>>> rtl/gtpr_checker.sv
// Port-level checks for the glyph text renderer, bound to the top level.
// Depends on gtpr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gtpr_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [gtpr_pkg::IN_DATA_W-1:0]  s_tdata,
  input logic [gtpr_pkg::OPCODE_W-1:0]   s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [gtpr_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            m_tlast,
  input logic                            psel,
  input logic                            penable,
  input logic                            pwrite,
  input logic [gtpr_pkg::APB_ADDR_W-1:0] paddr,
  input logic [gtpr_pkg::APB_DATA_W-1:0] pwdata,
  input logic [gtpr_pkg::APB_DATA_W-1:0] prdata,
  input logic                            pready
);

  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "Stalled output transaction changed.")
  `ASSERT_NEXT(a_clear_blocks_input, clk, 1'b0, rst, !s_tready, "Input accepted while the glyph store is being cleared.")
  `ASSERT_NEXT(a_reset_no_output, clk, 1'b0, rst, !m_tvalid, "Output transaction offered right after reset.")
  `ASSERT_SAME(a_cfg_ready, clk, rst, psel && penable, pready, "Configuration access not completed in its access cycle.")

endmodule

bind glyph_text_pixel_renderer gtpr_checker u_checker (.*);

>>> verif/glyph_pixel_checker.sv
// Checker for the glyph text pixel renderer: watches the command, pixel and register ports,
// predicts the pixel stream from its own glyph store and cursor, and counts mismatches.
// Depends on gtpr_pkg for widths, opcodes and constants.
`timescale 1ns / 1ps

module glyph_pixel_checker
  import gtpr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [OPCODE_W-1:0]   s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  m_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    mismatch_count,
  output int                    pixels_outstanding
);

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
  } pixel_t;

  logic [ROW_BITS_W-1:0] glyph_rows [NUM_GLYPHS_DEF][MAX_GLYPH_HEIGHT_DEF];
  logic [COORD_W-1:0]    cursor_x;
  logic [COORD_W-1:0]    cursor_y;
  logic [GEOM_W-1:0]     width_reg;
  logic [GEOM_W-1:0]     height_reg;
  pixel_t                expected_pixels[$];
  int                    errors_seen = 0;

  initial begin
    mismatch_count     = 0;
    pixels_outstanding = 0;
  end

  function automatic logic [COORD_W-1:0] clamp_add(int unsigned a, int unsigned b);
    return (a + b > COORD_MAX) ? COORD_MAX : COORD_W'(a + b);
  endfunction

  task automatic trace_command(logic [OPCODE_W-1:0] op, logic [CODE_W-1:0] cp,
                               logic [ROW_IDX_W-1:0] ri, logic [ROW_BITS_W-1:0] bits);
    int unsigned eff_w;
    int unsigned eff_h;
    pixel_t      held;
    bit          have_held;
    eff_w = (width_reg > MAX_GLYPH_WIDTH_DEF) ? MAX_GLYPH_WIDTH_DEF : width_reg;
    eff_h = (height_reg > MAX_GLYPH_HEIGHT_DEF) ? MAX_GLYPH_HEIGHT_DEF : height_reg;
    have_held = 1'b0;
    case (op)
      OP_WRITE_ROW: begin
        if (cp < NUM_GLYPHS_DEF && ri < MAX_GLYPH_HEIGHT_DEF) glyph_rows[cp][ri] = bits;
      end
      OP_START_PAGE: begin
        cursor_x = MARGIN;
        cursor_y = MARGIN;
      end
      OP_DRAW: begin
        if (cp == NEWLINE_CODE) begin
          cursor_x = MARGIN;
          cursor_y = clamp_add(cursor_y, eff_h);
        end else begin
          if (cp < NUM_GLYPHS_DEF) begin
            for (int unsigned col = 0; col < eff_w; col++) begin
              for (int unsigned row = 0; row < eff_h; row++) begin
                if (glyph_rows[cp][row][col]) begin
                  if (have_held) expected_pixels.push_back(held);
                  held.x    = clamp_add(cursor_x, col);
                  held.y    = clamp_add(cursor_y, row);
                  held.last = 1'b0;
                  have_held = 1'b1;
                end
              end
            end
            if (have_held) begin
              held.last = 1'b1;
              expected_pixels.push_back(held);
            end
          end
          cursor_x = clamp_add(cursor_x, eff_w);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    pixel_t want;
    pixel_t got;
    if (rst) begin
      foreach (glyph_rows[g, r]) glyph_rows[g][r] = '0;
      cursor_x   = MARGIN;
      cursor_y   = MARGIN;
      width_reg  = GEOM_RESET;
      height_reg = GEOM_RESET;
      expected_pixels.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_GLYPH_HEIGHT) height_reg = pwdata[GEOM_W-1:0];
        else width_reg = pwdata[GEOM_W-1:0];
      end
      if (s_tvalid && s_tready) begin
        trace_command(s_tuser, s_tdata[CODE_W-1:0], s_tdata[CODE_W+ROW_IDX_W-1:CODE_W],
                      s_tdata[CODE_W+ROW_IDX_W+ROW_BITS_W-1:CODE_W+ROW_IDX_W]);
      end
      if (m_tvalid && m_tready) begin
        got.x    = m_tdata[COORD_W-1:0];
        got.y    = m_tdata[2*COORD_W-1:COORD_W];
        got.last = m_tlast;
        if (expected_pixels.size() == 0) begin
          errors_seen++;
          if (errors_seen <= 10)
            $display("unexpected pixel transaction: x=%0d y=%0d last=%0b",
                     got.x, got.y, got.last);
        end else begin
          want = expected_pixels.pop_front();
          if (got.x != want.x || got.y != want.y || got.last != want.last) begin
            errors_seen++;
            if (errors_seen <= 10)
              $display("pixel mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                       want.x, want.y, want.last, got.x, got.y, got.last);
          end
        end
      end
    end
    pixels_outstanding <= expected_pixels.size();
    mismatch_count     <= errors_seen;
  end

endmodule

>>> verif/tb_glyph_text_pixel_renderer.sv
// Testbench top for the glyph text pixel renderer: clock, reset, command and register stimulus,
// output back-pressure and the verdict. Depends on gtpr_pkg, the renderer and glyph_pixel_checker.
`timescale 1ns / 1ps

module tb_glyph_text_pixel_renderer;
  import gtpr_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int DRAIN_CYCLES    = 300;
  localparam int STALL_CYCLES    = 600;
  localparam int ITEMS_PER_PHASE = 30;
  localparam int NUM_PHASES      = 8;
  localparam int WALK_ITEMS      = 50;
  localparam logic [CODE_W-1:0] GLYPH_A   = 21'd65;
  localparam logic [CODE_W-1:0] GLYPH_TOP = 21'd255;
  localparam logic [CODE_W-1:0] CODE_MAX  = 21'h1FFFFF;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [OPCODE_W-1:0]   s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int                    mismatch_count;
  int                    pixels_outstanding;

  bit                    hold_output = 1'b0;
  bit                    holding = 1'b0;
  bit                    no_gaps = 1'b0;
  logic [CODE_W-1:0]     glyph_pool [8];
  int                    idle_cycles;

  always #6 clk = ~clk;

  glyph_text_pixel_renderer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  glyph_pixel_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .mismatch_count(mismatch_count), .pixels_outstanding(pixels_outstanding)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(logic [OPCODE_W-1:0] op, logic [CODE_W-1:0] cp,
                           logic [ROW_IDX_W-1:0] ri, logic [ROW_BITS_W-1:0] bits);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {bits, ri, cp};
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic draw(logic [CODE_W-1:0] cp);
    send_item(OP_DRAW, cp, ROW_IDX_W'($urandom), ROW_BITS_W'($urandom));
  endtask

  task automatic settle_phase();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pixels_outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic index, logic [GEOM_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= {28'($urandom_range(0, 32'h0FFF_FFFF)), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_item();
    int                    r;
    logic [OPCODE_W-1:0]   op;
    logic [CODE_W-1:0]     cp;
    r  = $urandom_range(0, 99);
    cp = glyph_pool[$urandom_range(0, 7)];
    op = OP_DRAW;
    if (r < 22) op = OP_WRITE_ROW;
    else if (r < 26) begin
      op = OP_WRITE_ROW;
      cp = CODE_W'($urandom_range(0, CODE_MAX));
    end else if (r < 56) op = OP_DRAW;
    else if (r < 64) cp = NEWLINE_CODE;
    else if (r < 70) cp = CODE_W'($urandom_range(0, NUM_GLYPHS_DEF - 1));
    else if (r < 78) cp = CODE_W'($urandom_range(0, CODE_MAX));
    else if (r < 84) begin
      op = OP_START_PAGE;
      cp = CODE_W'($urandom_range(0, CODE_MAX));
    end else if (r < 88) begin
      op = OP_UNUSED;
      cp = CODE_W'($urandom_range(0, CODE_MAX));
    end
    send_item(op, cp, ROW_IDX_W'($urandom), ROW_BITS_W'($urandom));
  endtask

  // Output side: random back-pressure, with one long hold-off on request.
  initial begin
    int r;
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 19);
      if (hold_output) begin
        m_tready <= 1'b0;
        holding = 1'b1;
        repeat (STALL_CYCLES) @(posedge clk);
        hold_output = 1'b0;
        holding = 1'b0;
      end else if (r < 10) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else if (r < 13) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else if (r < 18) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat ($urandom_range(10, 60)) @(posedge clk);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
          (psel && penable && pwrite && pready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb_glyph_text_pixel_renderer: done, errors");
    $finish;
  end

  initial begin
    int phase_w [NUM_PHASES];
    int phase_h [NUM_PHASES];
    phase_w = '{8, 1, 15, 0, 6, 8, 3, 0};
    phase_h = '{8, 1, 15, 5, 0, 1, 7, 0};
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= OP_WRITE_ROW;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    draw(GLYPH_A);
    send_item(OP_WRITE_ROW, GLYPH_A, 3'd0, 8'hFF);
    send_item(OP_WRITE_ROW, GLYPH_A, 3'd7, 8'h81);
    send_item(OP_WRITE_ROW, GLYPH_A, 3'd3, 8'h5A);
    send_item(OP_WRITE_ROW, GLYPH_TOP, 3'd0, 8'h01);
    send_item(OP_WRITE_ROW, GLYPH_TOP, 3'd7, 8'h80);
    send_item(OP_WRITE_ROW, 21'd256, 3'd0, 8'hFF);
    send_item(OP_WRITE_ROW, CODE_MAX, 3'd7, 8'hFF);
    draw(GLYPH_A);
    draw(GLYPH_TOP);
    draw(21'd256);
    draw(CODE_MAX);
    draw(NEWLINE_CODE);
    send_item(OP_WRITE_ROW, NEWLINE_CODE, 3'd0, 8'hFF);
    draw(NEWLINE_CODE);
    send_item(OP_UNUSED, CODE_MAX, 3'd7, 8'hFF);
    draw(21'd0);
    send_item(OP_START_PAGE, CODE_MAX, 3'd7, 8'hFF);
    draw(GLYPH_A);
    settle_phase();

    no_gaps = 1'b1;
    send_item(OP_START_PAGE, 21'd0, 3'd0, 8'h00);
    for (int i = 0; i < WALK_ITEMS; i++)
      draw(CODE_W'($urandom_range(NUM_GLYPHS_DEF, CODE_MAX)));
    draw(GLYPH_A);
    draw(GLYPH_TOP);
    for (int i = 0; i < WALK_ITEMS; i++) draw(NEWLINE_CODE);
    draw(GLYPH_A);
    draw(GLYPH_TOP);
    no_gaps = 1'b0;
    settle_phase();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == NUM_PHASES - 1) begin
        phase_w[ph] = $urandom_range(0, 15);
        phase_h[ph] = $urandom_range(0, 15);
      end
      write_reg(REG_GLYPH_WIDTH, GEOM_W'(phase_w[ph]));
      write_reg(REG_GLYPH_HEIGHT, GEOM_W'(phase_h[ph]));
      glyph_pool[0] = 21'd0;
      glyph_pool[1] = GLYPH_TOP;
      glyph_pool[2] = GLYPH_A;
      for (int k = 3; k < 8; k++)
        glyph_pool[k] = CODE_W'($urandom_range(0, NUM_GLYPHS_DEF - 1));
      no_gaps = (ph == 1) || (ph % 3 == 2);
      if (ph == 1) begin
        hold_output = 1'b1;
        while (!holding) @(posedge clk);
      end
      draw(GLYPH_A);
      draw(GLYPH_TOP);
      repeat (ITEMS_PER_PHASE) random_item();
      settle_phase();
    end

    if (mismatch_count == 0)
      $display("tb_glyph_text_pixel_renderer: done, clean");
    else
      $display("tb_glyph_text_pixel_renderer: done, errors");
    $finish;
  end

endmodule
